// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, prop)
`define ASSERT_NEXT(label, clk, rstn, pre, post)
`endif
`endif

// ===== rtl/core/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc package
// shared constants and helpers for the compensation core
// ----------------------------------------------------------------------------
package ptc_pkg;
    localparam int unsigned NumStages  = 8;
    localparam int unsigned DivStages  = 32;
    localparam int unsigned PipeDepth  = NumStages + DivStages + 4;

    localparam logic [1:0] RegTemp      = 2'd0;
    localparam logic [1:0] RegPressLow  = 2'd1;
    localparam logic [1:0] RegPressHigh = 2'd2;
    localparam logic [1:0] RegPressNine = 2'd3;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        asr = 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] prod;
        prod = 64'(a) * 64'(b);
        mul32 = prod[31:0];
    endfunction
endpackage

// ===== rtl/core/pressure_temperature_compensation_core.sv =====
// ----------------------------------------------------------------------------
// pressure temperature compensation core
// 32-bit integer compensation of raw temperature and pressure conversions
// ----------------------------------------------------------------------------
// path: arithmetic stages, the divider pipeline and correction stages feed the output register
// throughput: one transaction per cycle unless the output stalls; a 32-stage divider pipeline sets depth
// the whole pipeline advances only when the output register can take data
// reset: synchronous active-low aresetn clears valid bits and coefficients
`include "assert_macros.svh"
module pressure_temperature_compensation_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // temperature_centi[15:0], pressure_pa[47:16]
                                   // pressure_invalid[48], zero fill above
);
    import ptc_pkg::*;

    // coefficient registers
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;
    logic [1:0]  reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_nine_reg  <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                RegTemp:      temp_coeffs_reg <= pwdata[47:0];
                RegPressLow:  press_low_reg   <= pwdata;
                RegPressHigh: press_high_reg  <= pwdata;
                RegPressNine: press_nine_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            RegTemp:      prdata = {16'd0, temp_coeffs_reg};
            RegPressLow:  prdata = press_low_reg;
            RegPressHigh: prdata = press_high_reg;
            RegPressNine: prdata = {48'd0, press_nine_reg};
            default:      prdata = '0;
        endcase
    end

    // coefficient unpacking
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    always_comb begin
        t1 = {16'd0, temp_coeffs_reg[15:0]};
        t2 = sx16(temp_coeffs_reg[31:16]);
        t3 = sx16(temp_coeffs_reg[47:32]);
        p1 = {16'd0, press_low_reg[15:0]};
        p2 = sx16(press_low_reg[31:16]);
        p3 = sx16(press_low_reg[47:32]);
        p4 = sx16(press_low_reg[63:48]);
        p5 = sx16(press_high_reg[15:0]);
        p6 = sx16(press_high_reg[31:16]);
        p7 = sx16(press_high_reg[47:32]);
        p8 = sx16(press_high_reg[63:48]);
        p9 = sx16(press_nine_reg);
    end

    // global stall: every stage moves together when the output can take data
    logic en;
    logic [PipeDepth-1:0] vld_reg;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PipeDepth-2:0], s_tvalid};
        end
    end

    // stage 1: temperature products
    logic [19:0] adcp1_reg;
    logic [31:0] ta1_reg, dd1_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            adcp1_reg <= s_tdata[39:20];
            ta1_reg   <= mul32({15'd0, s_tdata[19:3]} - (t1 << 1), t2);
            dd1_reg   <= mul32({16'd0, s_tdata[19:4]} - t1, {16'd0, s_tdata[19:4]} - t1);
        end
    end

    // stage 2
    logic [19:0] adcp2_reg;
    logic [31:0] ta2_reg, tb2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            adcp2_reg <= adcp1_reg;
            ta2_reg   <= asr(ta1_reg, 11);
            tb2_reg   <= mul32(asr(dd1_reg, 12), t3);
        end
    end

    // stage 3: fine temperature
    logic [19:0] adcp3_reg;
    logic [31:0] fine3_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            adcp3_reg <= adcp2_reg;
            fine3_reg <= ta2_reg + asr(tb2_reg, 14);
        end
    end

    // stage 4: temperature out, pressure var1 and square
    logic [19:0] adcp4_reg;
    logic [15:0] temp4_reg;
    logic [31:0] a4_reg, sq4_reg;
    logic [31:0] t_c, a_c;
    always_comb begin
        t_c = asr(mul32(fine3_reg, 32'd5) + 32'd128, 8);
        a_c = asr(fine3_reg, 1) - 32'd64000;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            adcp4_reg <= adcp3_reg;
            if (t_c[31]) begin
                temp4_reg <= (t_c < 32'hFFFF8000) ? 16'h8000 : t_c[15:0];
            end else begin
                temp4_reg <= (t_c > 32'h7FFF) ? 16'h7FFF : t_c[15:0];
            end
            a4_reg  <= a_c;
            sq4_reg <= mul32(asr(a_c, 2), asr(a_c, 2));
        end
    end

    // stage 5: products of var1 and square
    logic [19:0] adcp5_reg;
    logic [15:0] temp5_reg;
    logic [31:0] b6_5_reg, b5_5_reg, c3_5_reg, c2_5_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            adcp5_reg <= adcp4_reg;
            temp5_reg <= temp4_reg;
            b6_5_reg  <= mul32(asr(sq4_reg, 11), p6);
            b5_5_reg  <= mul32(a4_reg, p5) << 1;
            c3_5_reg  <= mul32(p3, asr(sq4_reg, 13));
            c2_5_reg  <= mul32(p2, a4_reg);
        end
    end

    // stage 6: var2 and var1 sum
    logic [19:0] adcp6_reg;
    logic [15:0] temp6_reg;
    logic [31:0] b6_reg, a6_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            adcp6_reg <= adcp5_reg;
            temp6_reg <= temp5_reg;
            b6_reg    <= asr(b6_5_reg + b5_5_reg, 2) + (p4 << 16);
            a6_reg    <= asr(asr(c3_5_reg, 3) + asr(c2_5_reg, 1), 18);
        end
    end

    // stage 7: divisor and numerator product
    logic [15:0] temp7_reg;
    logic [31:0] div7_reg, num7_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            temp7_reg <= temp6_reg;
            div7_reg  <= mul32(32'd32768 + a6_reg, p1);
            num7_reg  <= mul32((32'd1048576 - {12'd0, adcp6_reg}) - asr(b6_reg, 12),
                               32'd3125);
        end
    end

    // stage 8: divider operands
    logic [15:0] temp8_reg;
    logic [31:0] div8_reg, num8_reg;
    logic        big8_reg, inv8_reg;
    logic [31:0] dv_c;
    assign dv_c = asr(div7_reg, 15);
    always_ff @(posedge aclk) begin
        if (en) begin
            temp8_reg <= temp7_reg;
            div8_reg  <= dv_c;
            inv8_reg  <= (dv_c == 32'd0);
            big8_reg  <= num7_reg[31];
            num8_reg  <= num7_reg[31] ? num7_reg : (num7_reg << 1);
        end
    end

    // divider with sideband delay line
    logic [31:0] quo;
    ptc_divider u_div (
        .aclk(aclk), .en(en), .num(num8_reg), .den(div8_reg), .quo(quo)
    );

    logic [15:0] temp_dl_reg [DivStages];
    logic        big_dl_reg  [DivStages];
    logic        inv_dl_reg  [DivStages];
    always_ff @(posedge aclk) begin
        if (en) begin
            temp_dl_reg[0] <= temp8_reg;
            big_dl_reg[0]  <= big8_reg;
            inv_dl_reg[0]  <= inv8_reg;
            for (int i = 1; i < DivStages; i++) begin
                temp_dl_reg[i] <= temp_dl_reg[i-1];
                big_dl_reg[i]  <= big_dl_reg[i-1];
                inv_dl_reg[i]  <= inv_dl_reg[i-1];
            end
        end
    end

    // stages e1, e2, e3: pressure before correction, correction products and their sum
    logic [15:0] temp_e1_reg, temp_e2_reg, temp_e3_reg;
    logic        inv_e1_reg, inv_e2_reg, inv_e3_reg;
    logic [31:0] p_e1_reg, qq_e1_reg, p_e2_reg, c1m_e2_reg, c2_e2_reg, p_e3_reg, c1_e3_reg;
    logic [31:0] p_c, q_c;
    always_comb begin
        p_c = big_dl_reg[DivStages-1] ? (quo << 1) : quo;
        q_c = p_c >> 3;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            temp_e1_reg <= temp_dl_reg[DivStages-1];
            inv_e1_reg  <= inv_dl_reg[DivStages-1];
            p_e1_reg    <= p_c;
            qq_e1_reg   <= mul32(q_c, q_c);
            temp_e2_reg <= temp_e1_reg;
            inv_e2_reg  <= inv_e1_reg;
            p_e2_reg    <= p_e1_reg;
            c1m_e2_reg  <= mul32(p9, qq_e1_reg >> 13);
            c2_e2_reg   <= asr(mul32(p_e1_reg >> 2, p8), 13);
            temp_e3_reg <= temp_e2_reg;
            inv_e3_reg  <= inv_e2_reg;
            p_e3_reg    <= p_e2_reg;
            c1_e3_reg   <= asr(c1m_e2_reg, 12) + c2_e2_reg + p7;
        end
    end

    // output register
    logic [15:0] temp_out_reg;
    logic [31:0] press_out_reg;
    logic        inv_out_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            temp_out_reg  <= temp_e3_reg;
            inv_out_reg   <= inv_e3_reg;
            press_out_reg <= inv_e3_reg ? 32'd0 : p_e3_reg + asr(c1_e3_reg, 4);
        end
    end

    assign m_tvalid = vld_reg[PipeDepth-1];
    assign m_tdata  = {7'd0, inv_out_reg, press_out_reg, temp_out_reg};

    // assertions
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_IMPL(a_ready_follows, aclk, aresetn, s_tready == (!m_tvalid || m_tready))
    `ASSERT_IMPL(a_inv_zero, aclk, aresetn, m_tvalid && inv_out_reg |-> press_out_reg == 32'd0)
endmodule

// ===== rtl/core/ptc_divider.sv =====
// ----------------------------------------------------------------------------
// ptc divider
// pipelined 32-bit unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ptc_divider (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic [31:0] quo
);
    import ptc_pkg::*;

    for (genvar i = 0; i < DivStages; i++) begin : g_stage
        logic [31:0] rem_in, q_in, d_in;
        logic [31:0] rem_reg, q_reg, d_reg;
        logic [32:0] trial;
        logic [32:0] diff;
        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign q_in   = num;
            assign d_in   = den;
        end else begin : g_next
            assign rem_in = g_stage[i-1].rem_reg;
            assign q_in   = g_stage[i-1].q_reg;
            assign d_in   = g_stage[i-1].d_reg;
        end
        always_comb begin
            trial = {rem_in, q_in[31]};
            diff  = trial - {1'b0, d_in};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg <= d_in;
                if (!diff[32]) begin
                    rem_reg <= diff[31:0];
                    q_reg   <= {q_in[30:0], 1'b1};
                end else begin
                    rem_reg <= trial[31:0];
                    q_reg   <= {q_in[30:0], 1'b0};
                end
            end
        end
    end

    assign quo = g_stage[DivStages-1].q_reg;
endmodule
